[rtl/ioc_pkg.sv]
`default_nettype none

package ioc_pkg;

  localparam int unsigned PinCount = 8;
  localparam int unsigned PinW     = 3;
  localparam int unsigned IntCount = 4;
  localparam logic [7:0]  PinMask  = 8'((1 << PinCount) - 1);
  localparam logic [3:0]  SelNone  = 4'd8;
  localparam logic [3:0]  SelInt3  = 4'd3;

  typedef enum logic [2:0] {
    CfgInputMask     = 3'd0,
    CfgRiseEnable    = 3'd1,
    CfgFallEnable    = 3'd2,
    CfgIntMultiMode  = 3'd3,
    CfgIntPinSelect  = 3'd4,
    CfgIntEdges      = 3'd5,
    CfgIntEnables    = 3'd6,
    CfgIntPriorities = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    CmdPinEvent = 1'b0,
    CmdFlagWrite = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [7:0] input_mask;
    logic [7:0] rise_enable;
    logic [7:0] fall_enable;
    logic       int_multi_mode;
    logic [3:0] int_pin_select;
    logic [3:0] int_edges;
    logic [3:0] int_enables;
    logic [3:0] int_priorities;
  } cfg_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [PinW-1:0] pin_index;
    logic            pin_level;
    logic [7:0]      flag_value;
  } item_t;

  typedef struct packed {
    logic       wake;
    logic       irq_high;
    logic       irq_request;
    logic [3:0] int_flag_set;
    logic       change_irq;
    logic [7:0] change_flags;
    logic [7:0] levels;
  } result_t;

endpackage

`default_nettype wire

[rtl/ioc_cfg_regs.sv]
`default_nettype none

module ioc_cfg_regs
  import ioc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgInputMask:     cfg_d.input_mask     = cfg_data_i;
        CfgRiseEnable:    cfg_d.rise_enable    = cfg_data_i;
        CfgFallEnable:    cfg_d.fall_enable    = cfg_data_i;
        CfgIntMultiMode:  cfg_d.int_multi_mode = cfg_data_i[0];
        CfgIntPinSelect:  cfg_d.int_pin_select = cfg_data_i[3:0];
        CfgIntEdges:      cfg_d.int_edges      = cfg_data_i[3:0];
        CfgIntEnables:    cfg_d.int_enables    = cfg_data_i[3:0];
        CfgIntPriorities: cfg_d.int_priorities = cfg_data_i[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_mask     <= 8'hFF;
      cfg_q.rise_enable    <= 8'h00;
      cfg_q.fall_enable    <= 8'h00;
      cfg_q.int_multi_mode <= 1'b0;
      cfg_q.int_pin_select <= SelNone;
      cfg_q.int_edges      <= 4'hF;
      cfg_q.int_enables    <= 4'h0;
      cfg_q.int_priorities <= 4'hF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ioc_eval.sv]
`default_nettype none

module ioc_eval
  import ioc_pkg::*;
(
  input  wire cfg_t       cfg_i,
  input  wire item_t      item_i,
  input  wire logic [7:0] pin_state_i,
  input  wire logic [7:0] flag_reg_i,
  output result_t         res_o
);

  logic [7:0] bit_sel;
  logic       old_lvl;
  logic       idx_ok;
  logic       evt;
  logic       is_int_pin;
  logic [1:0] int_idx;
  logic       multi_active;
  logic       int_edge;
  logic [3:0] int_bit;
  logic [7:0] chg_en;
  logic       chg_hit;

  always_comb begin
    bit_sel      = 8'd1 << item_i.pin_index;
    old_lvl      = |(pin_state_i & bit_sel);
    idx_ok       = ({1'b0, item_i.pin_index} < 4'(PinCount));
    evt          = (item_i.cmd == CmdPinEvent) && idx_ok && (old_lvl != item_i.pin_level);
    is_int_pin   = (item_i.pin_index < 3'(IntCount));
    int_idx      = item_i.pin_index[1:0];
    int_bit      = 4'd1 << int_idx;
    multi_active = (item_i.pin_index < 3'd3) ||
                   ({1'b0, item_i.pin_index} == SelInt3 && cfg_i.int_pin_select == SelInt3);
    int_edge     = (item_i.pin_level == cfg_i.int_edges[int_idx]);
    chg_en       = item_i.pin_level ? cfg_i.rise_enable : cfg_i.fall_enable;
    chg_hit      = evt && |(cfg_i.input_mask & chg_en & bit_sel);

    res_o              = '0;
    res_o.levels       = pin_state_i;
    res_o.change_flags = flag_reg_i;

    if (item_i.cmd == CmdFlagWrite) begin
      res_o.change_flags = item_i.flag_value & PinMask;
    end else if (evt) begin
      if (cfg_i.int_multi_mode) begin
        if (is_int_pin && multi_active && int_edge) begin
          res_o.int_flag_set = int_bit;
          if (cfg_i.int_enables[int_idx]) begin
            res_o.wake        = 1'b1;
            res_o.irq_request = 1'b1;
            res_o.irq_high    = (int_idx == 2'd0) ? 1'b1 : cfg_i.int_priorities[int_idx];
          end
        end
      end else if ({1'b0, item_i.pin_index} == cfg_i.int_pin_select) begin
        if (item_i.pin_level == cfg_i.int_edges[0]) begin
          res_o.int_flag_set = 4'd1;
          res_o.wake         = cfg_i.int_enables[0];
        end
      end

      res_o.levels = item_i.pin_level ? (pin_state_i | bit_sel) : (pin_state_i & ~bit_sel);

      if (chg_hit) begin
        res_o.wake         = 1'b1;
        res_o.change_irq   = 1'b1;
        res_o.change_flags = flag_reg_i | bit_sel;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ioc_edge_interrupt_unit.sv]
// An input transfer is held in the input register, checked for edges, then its result is
// held in the result register. Throughput: one item per cycle unless the output stalls;
// pin levels and flags update as the result registers.
// Reset (rst_ni low, asynchronous): pin levels and change flags clear, both stages empty,
// configuration returns to its documented defaults.
`default_nettype none

module ioc_edge_interrupt_unit
  import ioc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // pin_index[2:0], pin_level[3], flag_value[11:4]
  input  wire logic        s_axis_tuser,  // cmd[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // levels[7:0], change_flags[15:8], change_irq[16],
                                          // int_flag_set[20:17], irq_request[21],
                                          // irq_high[22], wake[23]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  cfg_t       cfg;
  item_t      in_q;
  logic       in_valid_q;
  logic       in_valid_d;
  result_t    res;
  result_t    res_q;
  logic       out_valid_q;
  logic       out_valid_d;
  logic [7:0] pin_state_q;
  logic [7:0] flag_reg_q;
  logic       out_adv;
  logic       load;
  logic       in_xfer;

  ioc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ioc_eval u_eval (
    .cfg_i       (cfg),
    .item_i      (in_q),
    .pin_state_i (pin_state_q),
    .flag_reg_i  (flag_reg_q),
    .res_o       (res)
  );

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign load          = in_valid_q && out_adv;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pin_state_q <= 8'h00;
      flag_reg_q  <= 8'h00;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        pin_state_q <= res.levels;
        flag_reg_q  <= res.change_flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.cmd        <= cmd_e'(s_axis_tuser);
      in_q.pin_index  <= s_axis_tdata[2:0];
      in_q.pin_level  <= s_axis_tdata[3];
      in_q.flag_value <= s_axis_tdata[11:4];
    end
    if (load) begin
      res_q <= res;
    end
  end

  a_high_needs_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.irq_high |-> res_q.irq_request)
    else $error("irq_high without irq_request");

  a_req_needs_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.irq_request |-> $onehot(res_q.int_flag_set) && res_q.wake)
    else $error("irq_request without a single INT flag and wake");

  a_chg_wakes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.change_irq |-> res_q.wake)
    else $error("change interrupt without wake");

  a_state_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> pin_state_q == res_q.levels && flag_reg_q == res_q.change_flags)
    else $error("stored state differs from delivered result");

  a_flags_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flag_reg_q & ~PinMask) == 8'h00)
    else $error("change flag set beyond pin count");

endmodule

`default_nettype wire

[verif/ioc_edge_interrupt_unit_test.sv]
`timescale 1ns / 1ps

module ioc_edge_interrupt_unit_test;
  import ioc_pkg::*;

  class ioc_scoreboard;
    cfg_t       cfg;
    logic [7:0] levels;
    logic [7:0] flags;
    result_t    expected_q[$];
    int         mismatches;
    int         results_seen;
    int         flag_writes;
    int         change_irqs;
    int         int_edges_seen;
    int         requests;

    function new();
      cfg.input_mask     = 8'hFF;
      cfg.rise_enable    = '0;
      cfg.fall_enable    = '0;
      cfg.int_multi_mode = 1'b0;
      cfg.int_pin_select = SelNone;
      cfg.int_edges      = 4'hF;
      cfg.int_enables    = '0;
      cfg.int_priorities = 4'hF;
      levels             = '0;
      flags              = '0;
      mismatches         = 0;
      results_seen       = 0;
      flag_writes        = 0;
      change_irqs        = 0;
      int_edges_seen     = 0;
      requests           = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] v);
      case (idx)
        CfgInputMask:     cfg.input_mask     = v;
        CfgRiseEnable:    cfg.rise_enable    = v;
        CfgFallEnable:    cfg.fall_enable    = v;
        CfgIntMultiMode:  cfg.int_multi_mode = v[0];
        CfgIntPinSelect:  cfg.int_pin_select = v[3:0];
        CfgIntEdges:      cfg.int_edges      = v[3:0];
        CfgIntEnables:    cfg.int_enables    = v[3:0];
        CfgIntPriorities: cfg.int_priorities = v[3:0];
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      result_t    r;
      logic [7:0] pin_bit;
      logic [7:0] en;
      logic       active;
      r = '0;
      if (it.cmd == CmdFlagWrite) begin
        flags = it.flag_value & PinMask;
        flag_writes++;
      end else if (int'(it.pin_index) < PinCount && levels[it.pin_index] != it.pin_level) begin
        pin_bit = 8'd1 << it.pin_index;
        if (cfg.int_multi_mode) begin
          active = (it.pin_index < 3'd3) ||
                   (it.pin_index == 3'd3 && cfg.int_pin_select == SelInt3);
          if (active && it.pin_level == cfg.int_edges[it.pin_index[1:0]]) begin
            r.int_flag_set = pin_bit[3:0];
            if (cfg.int_enables[it.pin_index[1:0]]) begin
              r.wake        = 1'b1;
              r.irq_request = 1'b1;
              r.irq_high    = (it.pin_index == 3'd0) ? 1'b1 :
                              cfg.int_priorities[it.pin_index[1:0]];
            end
          end
        end else if ({1'b0, it.pin_index} == cfg.int_pin_select) begin
          if (it.pin_level == cfg.int_edges[0]) begin
            r.int_flag_set = 4'b0001;
            if (cfg.int_enables[0]) r.wake = 1'b1;
          end
        end
        levels[it.pin_index] = it.pin_level;
        en = it.pin_level ? cfg.rise_enable : cfg.fall_enable;
        if ((cfg.input_mask & en & pin_bit) != 8'd0) begin
          r.wake       = 1'b1;
          r.change_irq = 1'b1;
          flags        = flags | pin_bit;
        end
      end
      r.levels       = levels;
      r.change_flags = flags;
      if (r.change_irq) change_irqs++;
      if (r.int_flag_set != 4'd0) int_edges_seen++;
      if (r.irq_request) requests++;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      logic    bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result %h with nothing expected", got);
        return;
      end
      exp = expected_q.pop_front();
      results_seen++;
      bad = (got.levels !== exp.levels) || (got.change_flags !== exp.change_flags) ||
            (got.change_irq !== exp.change_irq) || (got.int_flag_set !== exp.int_flag_set) ||
            (got.irq_request !== exp.irq_request) || (got.irq_high !== exp.irq_high) ||
            (got.wake !== exp.wake);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d (levels flags chg int req high wake):",
                   results_seen);
          $display("  expected %h %h %b %h %b %b %b", exp.levels, exp.change_flags,
                   exp.change_irq, exp.int_flag_set, exp.irq_request, exp.irq_high, exp.wake);
          $display("  actual   %h %h %b %h %b %b %b", got.levels, got.change_flags,
                   got.change_irq, got.int_flag_set, got.irq_request, got.irq_high, got.wake);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int settings_run = 0;

  ioc_scoreboard sb = new();

  ioc_edge_interrupt_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin : monitor
    item_t it;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd        = cmd_e'(s_axis_tuser);
        it.pin_index  = s_axis_tdata[2:0];
        it.pin_level  = s_axis_tdata[3];
        it.flag_value = s_axis_tdata[11:4];
        sb.note_item(it);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(result_t'(m_axis_tdata));
    end
  end

  // hold off for a counted stretch, else stall at the phase rate
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(cmd_e cmd, logic [2:0] idx, logic lvl, logic [7:0] fval);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, fval, lvl, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random();
    cmd_e cmd;
    cmd = ($urandom_range(99) < 12) ? CmdFlagWrite : CmdPinEvent;
    send_item(cmd, 3'($urandom_range(7)), 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    drain();
    write_reg(CfgInputMask, c.input_mask);
    write_reg(CfgRiseEnable, c.rise_enable);
    write_reg(CfgFallEnable, c.fall_enable);
    write_reg(CfgIntMultiMode, {7'd0, c.int_multi_mode});
    write_reg(CfgIntPinSelect, {4'd0, c.int_pin_select});
    write_reg(CfgIntEdges, {4'd0, c.int_edges});
    write_reg(CfgIntEnables, {4'd0, c.int_enables});
    write_reg(CfgIntPriorities, {4'd0, c.int_priorities});
    settings_run++;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.input_mask     = 8'($urandom_range(255));
    c.rise_enable    = 8'($urandom_range(255));
    c.fall_enable    = 8'($urandom_range(255));
    c.int_multi_mode = 1'($urandom_range(1));
    if (c.int_multi_mode && $urandom_range(1) == 1) c.int_pin_select = SelInt3;
    else if ($urandom_range(9) == 0) c.int_pin_select = 4'hF;
    else c.int_pin_select = 4'($urandom_range(8));
    c.int_edges      = 4'($urandom_range(15));
    c.int_enables    = 4'($urandom_range(15));
    c.int_priorities = 4'($urandom_range(15));
    return c;
  endfunction

  initial begin : stimulus
    cfg_t c;
    int   i;
    int   phase;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no enables, no INT pin selected
    send_item(CmdPinEvent, 3'd0, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd7, 1'b1, 8'hFF);

    c.input_mask     = 8'h7F;
    c.rise_enable    = 8'hFF;
    c.fall_enable    = 8'hFF;
    c.int_multi_mode = 1'b1;
    c.int_pin_select = SelInt3;
    c.int_edges      = 4'b0101;
    c.int_enables    = 4'b1011;
    c.int_priorities = 4'b0100;
    apply_config(c);
    send_item(CmdPinEvent, 3'd0, 1'b0, 8'hFF);
    send_item(CmdPinEvent, 3'd0, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd0, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd1, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd1, 1'b0, 8'h00);
    send_item(CmdPinEvent, 3'd2, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd3, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd3, 1'b0, 8'h00);
    send_item(CmdPinEvent, 3'd7, 1'b0, 8'h00);
    send_item(CmdPinEvent, 3'd7, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd4, 1'b1, 8'h00);
    send_item(CmdFlagWrite, 3'd7, 1'b1, 8'hFF);
    send_item(CmdFlagWrite, 3'd0, 1'b0, 8'h00);
    send_item(CmdFlagWrite, 3'd5, 1'b1, 8'hA5);

    // single INT pin on pin 5, falling edge; then no pin selected
    c.int_multi_mode = 1'b0;
    c.int_pin_select = 4'd5;
    c.int_edges      = 4'b1110;
    c.int_enables    = 4'b0001;
    apply_config(c);
    send_item(CmdPinEvent, 3'd5, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd5, 1'b0, 8'h00);
    send_item(CmdPinEvent, 3'd0, 1'b0, 8'h00);
    c.int_pin_select = 4'hF;
    c.int_edges      = 4'b0000;
    apply_config(c);
    send_item(CmdPinEvent, 3'd0, 1'b1, 8'h00);
    send_item(CmdPinEvent, 3'd0, 1'b0, 8'h00);

    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        c = '1;
        c.int_multi_mode = 1'b1;
        c.int_pin_select = SelInt3;
      end else if (phase == 1) begin
        c = '0;
      end else begin
        c = random_config();
      end
      apply_config(c);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      if (phase == 4) rx_hold_left = 300;
      for (i = 0; i < 240; i++) begin
        if (phase == 5 && i == 120) drain();
        send_random();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results across %0d settings: %0d flag writes,", sb.results_seen,
             settings_run, sb.flag_writes);
    $display("%0d change interrupts, %0d INT edges, %0d INT requests.", sb.change_irqs,
             sb.int_edges_seen, sb.requests);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
